FILE: rtl/pig_pkg.sv
// ----------------------------------------------------------------------------
// pig_pkg
// Shared types for the primitive index generator: primitive kinds and the
// command and status words between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pig_pkg;

  // Widths fixed by the descriptor and result formats
  localparam int unsigned CountW = 7;
  localparam int unsigned KindW  = 8;
  localparam int unsigned IndexW = 16;

  // Raw kind codes on the input
  localparam logic [KindW-1:0] KindCodeStrip = 8'd1;
  localparam logic [KindW-1:0] KindCodeList  = 8'd2;

  // Smallest vertex count that yields a triangle
  localparam logic [CountW-1:0] MinVerts = 7'd3;

  typedef enum logic [1:0] {
    KIND_FAN,
    KIND_STRIP,
    KIND_LIST
  } kind_e;

  // Controller to datapath
  typedef struct packed {
    logic load;   // descriptor word accepted this cycle
    logic step;   // issue the current triangle into the output register
  } pig_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_tris;  // incoming descriptor has at least three vertices
    logic last;      // current triangle closes the primitive
  } pig_status_t;

endpackage

`default_nettype wire

FILE: rtl/pig_ctrl.sv
// ----------------------------------------------------------------------------
// pig_ctrl
// Sequencer: accepts one descriptor word, then issues one triangle per cycle
// into the output register while it is free or being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module pig_ctrl
  import pig_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  input  wire pig_status_t status_i,
  output      pig_cmd_t    cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  // Accept only between primitives
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  assign cmd_o.load = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.step = (state_q == ST_RUN) && (!out_valid_q || out_ready_i);

  // Hold state and the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.load && status_i.has_tris) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (cmd_o.step && status_i.last) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pig_dp.sv
// ----------------------------------------------------------------------------
// pig_dp
// Datapath: running base vertex, per-primitive counters, index arithmetic and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pig_dp
  import pig_pkg::*;
#(
  parameter int unsigned MAX_VERTS = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [CountW-1:0] vertex_count_i,
  input  wire logic [KindW-1:0]  prim_kind_i,
  input  wire logic              batch_start_i,
  input  wire pig_cmd_t          cmd_i,
  output      pig_status_t       status_o,
  output      logic [IndexW-1:0] index_a_o,
  output      logic [IndexW-1:0] index_b_o,
  output      logic [IndexW-1:0] index_c_o,
  output      logic              last_triangle_o
);

  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_VERTS);

  logic [IndexW-1:0] base_q;
  logic [IndexW-1:0] prim_base_q;
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] offset_q;
  kind_e             kind_q;

  logic [IndexW-1:0] base_eff;
  logic [CountW-1:0] count_sat;
  kind_e             kind_dec;
  logic [IndexW-1:0] bt;
  logic [IndexW-1:0] bt1;
  logic [IndexW-1:0] bt2;
  logic [CountW:0]   off_ext;
  logic [IndexW-1:0] tri_a;
  logic [IndexW-1:0] tri_b;
  logic [IndexW-1:0] tri_c;
  logic              tri_last;

  // Decode and saturate the incoming descriptor
  always_comb begin
    base_eff  = batch_start_i ? '0 : base_q;
    count_sat = (vertex_count_i > MaxCount) ? MaxCount : vertex_count_i;
    if (prim_kind_i == KindCodeStrip) begin
      kind_dec = KIND_STRIP;
    end else if (prim_kind_i == KindCodeList) begin
      kind_dec = KIND_LIST;
    end else begin
      kind_dec = KIND_FAN;
    end
  end

  assign status_o.has_tris = (count_sat >= MinVerts);

  // Triangle at the current offset, reversed winding
  always_comb begin
    off_ext = {1'b0, offset_q};
    bt      = prim_base_q + IndexW'(offset_q);
    bt1     = bt + IndexW'(1);
    bt2     = bt + IndexW'(2);
    tri_b   = bt2;
    case (kind_q)
      KIND_STRIP: begin
        tri_a    = offset_q[0] ? bt1 : bt;
        tri_c    = offset_q[0] ? bt : bt1;
        tri_last = (off_ext + (CountW+1)'(3)) == {1'b0, count_q};
      end
      KIND_LIST: begin
        tri_a    = bt;
        tri_c    = bt1;
        tri_last = (off_ext + (CountW+1)'(6)) > {1'b0, count_q};
      end
      default: begin
        tri_a    = prim_base_q;
        tri_c    = bt1;
        tri_last = (off_ext + (CountW+1)'(3)) == {1'b0, count_q};
      end
    endcase
  end

  assign status_o.last = tri_last;

  // Advance the base on accept; a short primitive only takes the batch clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cmd_i.load) begin
      if (status_o.has_tris) begin
        base_q <= base_eff + IndexW'(count_sat);
      end else begin
        base_q <= base_eff;
      end
    end
  end

  // Latch the primitive, step the offset, load the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      prim_base_q <= base_eff;
      count_q     <= count_sat;
      kind_q      <= kind_dec;
      offset_q    <= '0;
    end else if (cmd_i.step) begin
      offset_q <= offset_q + ((kind_q == KIND_LIST) ? CountW'(3) : CountW'(1));
    end
    if (cmd_i.step) begin
      index_a_o       <= tri_a;
      index_b_o       <= tri_b;
      index_c_o       <= tri_c;
      last_triangle_o <= tri_last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/primitive_index_generator_core.sv
// ----------------------------------------------------------------------------
// primitive_index_generator_core
// Expands fan, strip and list descriptors into triangle index triples.
//
//   Channel   Direction  Handshake               Word
//   in        input      in_valid_i/in_ready_o   vertex_count, prim_kind, batch_start
//   out       output     out_valid_o/out_ready_i index_a/b/c, last_triangle
//
// A primitive is taken as one descriptor word and expanded into n - 2
// triangles for fan and strip or n/3 for list; under three vertices it
// yields none. Reset clears the base vertex to zero and empties the output.
// A stalled output holds the sequencer; no descriptor is taken mid-primitive.
// ----------------------------------------------------------------------------
`default_nettype none

module primitive_index_generator_core
  import pig_pkg::*;
#(
  parameter int unsigned MAX_VERTS = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire logic [CountW-1:0] vertex_count_i,
  input  wire logic [KindW-1:0]  prim_kind_i,
  input  wire logic              batch_start_i,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      logic [IndexW-1:0] index_a_o,
  output      logic [IndexW-1:0] index_b_o,
  output      logic [IndexW-1:0] index_c_o,
  output      logic              last_triangle_o
);

  pig_cmd_t    cmd;
  pig_status_t status;

  // Sequencer
  pig_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Index arithmetic and output register
  pig_dp #(
    .MAX_VERTS (MAX_VERTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .vertex_count_i  (vertex_count_i),
    .prim_kind_i     (prim_kind_i),
    .batch_start_i   (batch_start_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .index_a_o       (index_a_o),
    .index_b_o       (index_b_o),
    .index_c_o       (index_c_o),
    .last_triangle_o (last_triangle_o)
  );

endmodule

`default_nettype wire

FILE: tb/tb_primitive_index_generator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_primitive_index_generator_core
// Self-checking bench for the fan, strip and list index generator. A directed
// set of descriptors covers the kinds, the count extremes, short primitives,
// list leftovers and saturation. Random descriptors follow under changing
// idle patterns, with one long output stall while descriptors keep coming.
// Every triangle is predicted in the bench and checked field by field, in
// order.
// ----------------------------------------------------------------------------

import pig_pkg::*;

typedef struct packed {
  logic [IndexW-1:0] idx_a;
  logic [IndexW-1:0] idx_b;
  logic [IndexW-1:0] idx_c;
  logic              last;
} triangle_t;

// Predicts the triangles of each accepted descriptor and checks them in order
class triangle_scoreboard;
  logic [IndexW-1:0] base_vertex;
  triangle_t         pending_tris[$];
  int unsigned       mismatches;
  int unsigned       max_verts;

  function new(int unsigned verts_limit);
    base_vertex = '0;
    mismatches  = 0;
    max_verts   = verts_limit;
  endfunction

  task report(string msg);
    mismatches++;
    if (mismatches <= 40) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task note_primitive(logic [CountW-1:0] count, logic [KindW-1:0] code, logic start);
    int unsigned       n;
    int unsigned       num_tris;
    kind_e             kind;
    logic [IndexW-1:0] b;
    triangle_t         tr;
    if (start) base_vertex = '0;
    n = 32'(count);
    if (n > max_verts) n = max_verts;
    if (n < MinVerts) return;
    if (code == KindCodeStrip) kind = KIND_STRIP;
    else if (code == KindCodeList) kind = KIND_LIST;
    else kind = KIND_FAN;
    b = base_vertex;
    num_tris = (kind == KIND_LIST) ? n / 3 : n - 2;
    for (int unsigned t = 0; t < num_tris; t++) begin
      case (kind)
        KIND_STRIP: begin
          if (t % 2 == 0) begin
            tr.idx_a = IndexW'(b + t);
            tr.idx_b = IndexW'(b + t + 2);
            tr.idx_c = IndexW'(b + t + 1);
          end else begin
            tr.idx_a = IndexW'(b + t + 1);
            tr.idx_b = IndexW'(b + t + 2);
            tr.idx_c = IndexW'(b + t);
          end
        end
        KIND_LIST: begin
          tr.idx_a = IndexW'(b + 3 * t);
          tr.idx_b = IndexW'(b + 3 * t + 2);
          tr.idx_c = IndexW'(b + 3 * t + 1);
        end
        default: begin
          tr.idx_a = b;
          tr.idx_b = IndexW'(b + t + 2);
          tr.idx_c = IndexW'(b + t + 1);
        end
      endcase
      tr.last = (t + 1 == num_tris);
      pending_tris.insert(pending_tris.size(), tr);
    end
    // Advance the base by the full saturated count, list leftovers included
    base_vertex = IndexW'(b + n);
  endtask

  task check_triangle(triangle_t got);
    triangle_t want;
    if (pending_tris.size() == 0) begin
      report($sformatf("unexpected triangle (%0d, %0d, %0d) last %0b",
                       got.idx_a, got.idx_b, got.idx_c, got.last));
      return;
    end
    want = pending_tris.pop_front();
    if (got.idx_a !== want.idx_a)
      report($sformatf("index_a %0d, expected %0d", got.idx_a, want.idx_a));
    if (got.idx_b !== want.idx_b)
      report($sformatf("index_b %0d, expected %0d", got.idx_b, want.idx_b));
    if (got.idx_c !== want.idx_c)
      report($sformatf("index_c %0d, expected %0d", got.idx_c, want.idx_c));
    if (got.last !== want.last)
      report($sformatf("last_triangle %0b, expected %0b", got.last, want.last));
  endtask
endclass

module tb_primitive_index_generator_core;

  localparam int unsigned    MaxVerts      = 64;
  localparam int unsigned    ResetCycles   = 11;
  localparam int unsigned    HoldCycles    = 300;
  localparam int unsigned    SettleCycles  = 32;
  localparam int unsigned    QuietLimit    = 3000;
  localparam logic [KindW-1:0] KindCodeFan = 8'd0;
  localparam logic [KindW-1:0] KindCodeOdd = 8'd3;

  logic              clk_i;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [CountW-1:0] vertex_count_i = '0;
  logic [KindW-1:0]  prim_kind_i    = '0;
  logic              batch_start_i  = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [IndexW-1:0] index_a_o;
  logic [IndexW-1:0] index_b_o;
  logic [IndexW-1:0] index_c_o;
  logic              last_triangle_o;

  triangle_scoreboard sb;
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_idle_pct = 0;
  int unsigned        hold_requests = 0;

  primitive_index_generator_core #(
    .MAX_VERTS(MaxVerts)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .vertex_count_i (vertex_count_i),
    .prim_kind_i    (prim_kind_i),
    .batch_start_i  (batch_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .index_a_o      (index_a_o),
    .index_b_o      (index_b_o),
    .index_c_o      (index_c_o),
    .last_triangle_o(last_triangle_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Offer one descriptor word, idling first at random, and hold it until taken
  task automatic send_primitive(input logic [CountW-1:0] count, input logic [KindW-1:0] code,
                                input logic start);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i     <= 1'b1;
    vertex_count_i <= count;
    prim_kind_i    <= code;
    batch_start_i  <= start;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_primitive(count, code, start);
  endtask

  // Draw a descriptor weighted towards short primitives and the known kinds
  task automatic send_random(input logic allow_start);
    logic [CountW-1:0] count;
    logic [KindW-1:0]  code;
    int unsigned       r;
    r = $urandom_range(99);
    if (r < 10) count = CountW'($urandom_range(2));
    else if (r < 55) count = CountW'($urandom_range(8, 3));
    else if (r < 80) count = CountW'($urandom_range(63, 9));
    else if (r < 90) count = CountW'(MaxVerts);
    else count = CountW'($urandom_range(127, 65));
    r = $urandom_range(99);
    if (r < 30) code = KindCodeFan;
    else if (r < 60) code = KindCodeStrip;
    else if (r < 90) code = KindCodeList;
    else code = KindW'($urandom_range(255, KindCodeOdd));
    send_primitive(count, code, allow_start && ($urandom_range(99) < 8));
  endtask

  // Drop valid and wait until every predicted triangle has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending_tris.size() != 0);
  endtask

  // Receiver: check accepted words, then pick ready for the next cycle
  initial begin
    int unsigned hold_left;
    int unsigned holds_done;
    triangle_t   got;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.idx_a = index_a_o;
        got.idx_b = index_b_o;
        got.idx_c = index_c_o;
        got.last  = last_triangle_o;
        sb.check_triangle(got);
      end
      if (hold_left != 0) begin
        hold_left--;
      end else if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = HoldCycles;
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
      if (quiet >= QuietLimit) begin
        $display("timeout: no handshake for %0d cycles", QuietLimit);
        $display("primitive_index_generator_core test failed");
        $finish;
      end
    end
  end

  initial begin
    sb = new(MaxVerts);
    send_idle_pct = 9;
    recv_idle_pct = 61;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: each kind at its minimum, strip winding, list leftovers
    send_primitive(7'd3, KindCodeFan, 1'b1);
    send_primitive(7'd3, KindCodeStrip, 1'b0);
    send_primitive(7'd3, KindCodeList, 1'b0);
    send_primitive(7'd4, KindCodeStrip, 1'b0);
    send_primitive(7'd5, KindCodeList, 1'b0);
    send_primitive(7'd4, KindCodeList, 1'b0);
    // Short primitives emit nothing; a short one may still clear the base
    send_primitive(7'd2, KindCodeFan, 1'b0);
    send_primitive(7'd0, KindCodeStrip, 1'b0);
    send_primitive(7'd1, KindCodeList, 1'b1);
    send_primitive(7'd6, KindCodeStrip, 1'b0);
    // Unknown kinds fall back to fan
    send_primitive(7'd5, KindCodeOdd, 1'b0);
    send_primitive(7'd6, 8'hFF, 1'b0);
    send_primitive(7'd7, 8'h80, 1'b0);
    // Largest primitives and saturated counts
    send_primitive(7'd64, KindCodeStrip, 1'b0);
    send_primitive(7'd64, KindCodeFan, 1'b0);
    send_primitive(7'd127, KindCodeList, 1'b0);
    send_primitive(7'd65, KindCodeStrip, 1'b0);
    send_primitive(7'd127, KindCodeFan, 1'b1);
    send_primitive(7'd64, KindCodeList, 1'b0);
    send_primitive(7'd100, KindCodeStrip, 1'b0);
    send_primitive(7'd2, KindCodeList, 1'b1);

    // Random, with one long output stall while descriptors keep coming
    repeat (40) send_random(1'b1);
    hold_requests++;
    repeat (80) send_random(1'b1);
    drain_results();

    send_idle_pct = 61;
    recv_idle_pct = 9;
    repeat (120) send_random(1'b1);
    drain_results();

    // No idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (100) send_random(1'b1);
    drain_results();

    repeat (SettleCycles) @(posedge clk_i);
    if (sb.pending_tris.size() != 0)
      sb.report($sformatf("%0d triangles never arrived", sb.pending_tris.size()));
    if (sb.mismatches == 0) begin
      $display("primitive_index_generator_core test passed");
    end else begin
      $display("primitive_index_generator_core test failed");
    end
    $finish;
  end

endmodule
